// ===== rtl/core/dual_channel_fir_lowpass_macros.svh =====
// assertion macros for the dual channel fir lowpass checker
// no dependencies
`ifndef DUAL_CHANNEL_FIR_LOWPASS_MACROS_SVH
`define DUAL_CHANNEL_FIR_LOWPASS_MACROS_SVH

// checked only while out of reset
`define DCFL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DCFL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/dcfl_pkg.sv =====
// shared constants, tap table, coefficient function and control types
// no dependencies
`timescale 1ns / 1ps

package dcfl_pkg;

    localparam int SAMPLE_BITS        = 16;
    localparam int DEF_TAP_COUNT      = 51;
    localparam int DEF_COEF_FRAC_BITS = 15;
    localparam int TABLE_FRAC_BITS    = 20;
    localparam int TABLE_W            = 16;
    localparam int HALF_TAPS          = 26;
    localparam int BASE_TAPS          = 51;
    localparam int HALF_IW            = $clog2(HALF_TAPS);
    localparam int DIGIT_W            = 4;

    typedef logic [TABLE_W-1:0] t_tap_q20;

    // first half of the symmetric tap set, q0.20
    localparam t_tap_q20 TAP_HALF_Q20 [HALF_TAPS] = '{
        16'd0,     16'd173,   16'd404,   16'd743,   16'd1242,  16'd1950,
        16'd2915,  16'd4176,  16'd5763,  16'd7694,  16'd9972,  16'd12588,
        16'd15513, 16'd18705, 16'd22107, 16'd25648, 16'd29247, 16'd32815,
        16'd36258, 16'd39481, 16'd42392, 16'd44904, 16'd46944, 16'd48447,
        16'd49369, 16'd49679
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic step;
        logic first;
        logic flush;
    } t_mac_ctrl;

    typedef struct packed {
        logic load;
        logic rotate;
    } t_ring_ctrl;

    // tap at position pos, rounded half up to frac_bits fraction bits
    function automatic t_tap_q20 f_coef(input int pos, input int frac_bits);
        int                 sh;
        int                 p;
        logic [TABLE_W:0]   t;
        sh = TABLE_FRAC_BITS - frac_bits;
        p  = pos;
        if (p >= BASE_TAPS) begin
            return '0;
        end
        if (p >= HALF_TAPS) begin
            p = BASE_TAPS - 1 - p;
        end
        t = {1'b0, TAP_HALF_Q20[HALF_IW'(p)]};
        if (sh > 0) begin
            t = (t + (TABLE_W+1)'(1 << (sh - 1))) >> sh;
        end
        return t[TABLE_W-1:0];
    endfunction

endpackage

// ===== rtl/core/dual_channel_fir_lowpass.sv =====
// Two-channel 51-tap symmetric low-pass FIR for red and infrared AC samples.
// Each input beat shifts one sample into each channel's delay line; one output
// beat follows with both filtered values, rounded half up and saturated to 16
// bits, and the two DC values copied through. Within a beat the multiplier takes
// each tap coefficient four bits per cycle while the delay line rotates one
// sample past it per tap. An output register holds the finished beat, so the
// next input beat is taken while it waits.
// depends on dcfl_pkg, dcfl_ring, dcfl_mac, dcfl_ctrl
`timescale 1ns / 1ps

module dual_channel_fir_lowpass
    import dcfl_pkg::*;
#(
    parameter int TAP_COUNT      = DEF_TAP_COUNT,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_red_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_ir_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_red_dc_in,
    input  logic signed [SAMPLE_BITS-1:0] i_ir_dc_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_red_filtered,
    output logic signed [SAMPLE_BITS-1:0] o_ir_filtered,
    output logic signed [SAMPLE_BITS-1:0] o_red_dc_out,
    output logic signed [SAMPLE_BITS-1:0] o_ir_dc_out
);

    localparam int COEF_BITS = COEF_FRAC_BITS - 3;
    localparam int DIGITS    = (COEF_BITS + DIGIT_W - 1) / DIGIT_W;

    t_ring_ctrl                    w_ring;
    t_mac_ctrl                     w_mac;
    logic [DIGIT_W-1:0]            w_digit;
    logic                          w_load_out;
    logic                          w_out_free;
    logic                          w_in_stall;
    logic signed [SAMPLE_BITS-1:0] w_red_head;
    logic signed [SAMPLE_BITS-1:0] w_ir_head;
    logic signed [SAMPLE_BITS-1:0] w_red_result;
    logic signed [SAMPLE_BITS-1:0] w_ir_result;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_red_filtered;
    logic signed [SAMPLE_BITS-1:0] r_ir_filtered;
    logic signed [SAMPLE_BITS-1:0] r_red_dc_out;
    logic signed [SAMPLE_BITS-1:0] r_ir_dc_out;
    logic signed [SAMPLE_BITS-1:0] r_red_dc_hold;
    logic signed [SAMPLE_BITS-1:0] r_ir_dc_hold;

    assign w_out_free = !r_out_valid || !i_out_stall;

    dcfl_ctrl #(
        .TAP_COUNT      (TAP_COUNT),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .DIGITS         (DIGITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .o_in_stall (w_in_stall),
        .o_load_out (w_load_out),
        .o_ring     (w_ring),
        .o_mac      (w_mac),
        .o_digit    (w_digit)
    );

    dcfl_ring #(
        .TAP_COUNT (TAP_COUNT)
    ) u_red_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ring),
        .i_sample (i_red_sample),
        .o_head   (w_red_head)
    );

    dcfl_ring #(
        .TAP_COUNT (TAP_COUNT)
    ) u_ir_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ring),
        .i_sample (i_ir_sample),
        .o_head   (w_ir_head)
    );

    dcfl_mac #(
        .TAP_COUNT      (TAP_COUNT),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .DIGITS         (DIGITS)
    ) u_red_mac (
        .i_clk    (i_clk),
        .i_ctrl   (w_mac),
        .i_sample (w_red_head),
        .i_digit  (w_digit),
        .o_result (w_red_result)
    );

    dcfl_mac #(
        .TAP_COUNT      (TAP_COUNT),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .DIGITS         (DIGITS)
    ) u_ir_mac (
        .i_clk    (i_clk),
        .i_ctrl   (w_mac),
        .i_sample (w_ir_head),
        .i_digit  (w_digit),
        .o_result (w_ir_result)
    );

    // dc values wait here until the filtered beat is ready
    always_ff @(posedge i_clk) begin
        if (w_ring.load) begin
            r_red_dc_hold <= i_red_dc_in;
            r_ir_dc_hold  <= i_ir_dc_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_red_filtered <= w_red_result;
            r_ir_filtered  <= w_ir_result;
            r_red_dc_out   <= r_red_dc_hold;
            r_ir_dc_out    <= r_ir_dc_hold;
        end
    end

    assign o_in_stall     = w_in_stall;
    assign o_out_valid    = r_out_valid;
    assign o_red_filtered = r_red_filtered;
    assign o_ir_filtered  = r_ir_filtered;
    assign o_red_dc_out   = r_red_dc_out;
    assign o_ir_dc_out    = r_ir_dc_out;

endmodule

// ===== rtl/core/dcfl_ring.sv =====
// rotating sample delay line for one channel, newest sample at the head
// depends on dcfl_pkg
`timescale 1ns / 1ps

module dcfl_ring
    import dcfl_pkg::*;
#(
    parameter int TAP_COUNT = DEF_TAP_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ring_ctrl                    i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_head
);

    logic signed [SAMPLE_BITS-1:0] r_line [TAP_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAP_COUNT; k++) begin
                r_line[k] <= '0;
            end
        end else if (i_ctrl.load) begin
            for (int k = TAP_COUNT - 1; k > 0; k--) begin
                r_line[k] <= r_line[k-1];
            end
            r_line[0] <= i_sample;
        end else if (i_ctrl.rotate) begin
            for (int k = 0; k < TAP_COUNT - 1; k++) begin
                r_line[k] <= r_line[k+1];
            end
            r_line[TAP_COUNT-1] <= r_line[0];
        end
    end

    assign o_head = r_line[0];

endmodule

// ===== rtl/core/dcfl_mac.sv =====
// digit-serial multiply-accumulate with rounding and saturation, one channel
// depends on dcfl_pkg
`timescale 1ns / 1ps

module dcfl_mac
    import dcfl_pkg::*;
#(
    parameter int TAP_COUNT      = DEF_TAP_COUNT,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    parameter int DIGITS         = 3
) (
    input  logic                          i_clk,
    input  t_mac_ctrl                     i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic        [DIGIT_W-1:0]     i_digit,
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    localparam int CPAD_W = DIGITS * DIGIT_W;
    localparam int PP_W   = SAMPLE_BITS + DIGIT_W + 1;
    localparam int PROD_W = SAMPLE_BITS + CPAD_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT) + 1;
    localparam int UP_W   = ACC_W - SAMPLE_BITS + 1;

    logic signed [PP_W-1:0]        w_pp;
    logic signed [PROD_W-1:0]      w_pp_ext;
    logic signed [PROD_W-1:0]      n_prod;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       w_prod_ext;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       w_q;
    logic        [UP_W-1:0]        w_upper;
    logic                          w_acc_add;

    assign w_pp       = i_sample * $signed({1'b0, i_digit});
    assign w_pp_ext   = {{(PROD_W-PP_W){w_pp[PP_W-1]}}, w_pp};
    assign n_prod     = (i_ctrl.first ? PROD_W'(0) : (r_prod <<< DIGIT_W)) + w_pp_ext;
    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_acc_add  = (i_ctrl.step && i_ctrl.first) || i_ctrl.flush;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_acc  <= ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
            r_prod <= '0;
        end else begin
            if (w_acc_add) begin
                r_acc <= r_acc + w_prod_ext;
            end
            if (i_ctrl.step) begin
                r_prod <= n_prod;
            end
        end
    end

    assign w_q     = r_acc >>> COEF_FRAC_BITS;
    assign w_upper = w_q[ACC_W-1:SAMPLE_BITS-1];

    always_comb begin
        if (w_upper == '0 || w_upper == '1) begin
            o_result = w_q[SAMPLE_BITS-1:0];
        end else if (w_q[ACC_W-1]) begin
            o_result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/core/dcfl_ctrl.sv =====
// sequencer: tap and digit counters, coefficient digit select, beat handshake
// depends on dcfl_pkg
`timescale 1ns / 1ps

module dcfl_ctrl
    import dcfl_pkg::*;
#(
    parameter int TAP_COUNT      = DEF_TAP_COUNT,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    parameter int DIGITS         = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_free,
    output logic               o_in_stall,
    output logic               o_load_out,
    output t_ring_ctrl         o_ring,
    output t_mac_ctrl          o_mac,
    output logic [DIGIT_W-1:0] o_digit
);

    localparam int TAP_CW = $clog2(TAP_COUNT);
    localparam int DIG_CW = $clog2(DIGITS);
    localparam int CPAD_W = DIGITS * DIGIT_W;

    t_state                    r_state;
    t_state                    n_state;
    logic [TAP_CW-1:0]         r_tap;
    logic [DIG_CW-1:0]         r_dig;
    logic                      w_accept;
    logic                      w_dig_last;
    logic                      w_tap_last;
    t_tap_q20                  w_coef;
    logic [CPAD_W+TABLE_W-1:0] w_coef_wide;
    logic [CPAD_W-1:0]         w_coef_pad;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_dig_last = (r_dig == '0);
    assign w_tap_last = (r_tap == TAP_CW'(TAP_COUNT - 1));

    // coefficient digits go out most significant first
    assign w_coef      = f_coef(int'(r_tap), COEF_FRAC_BITS);
    assign w_coef_wide = {{CPAD_W{1'b0}}, w_coef};
    assign w_coef_pad  = w_coef_wide[CPAD_W-1:0];
    assign o_digit     = DIGIT_W'(w_coef_pad >> (int'(r_dig) * DIGIT_W));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_dig   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_tap <= '0;
                r_dig <= DIG_CW'(DIGITS - 1);
            end else if (r_state == S_RUN) begin
                if (w_dig_last) begin
                    r_dig <= DIG_CW'(DIGITS - 1);
                    r_tap <= TAP_CW'(r_tap + 1'b1);
                end else begin
                    r_dig <= r_dig - 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_dig_last && w_tap_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_load_out = 1'b0;
        o_ring     = '0;
        o_mac      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_ring.load = i_in_valid;
                o_mac.clear = i_in_valid;
            end
            S_RUN: begin
                o_mac.step    = 1'b1;
                o_mac.first   = (r_dig == DIG_CW'(DIGITS - 1));
                o_ring.rotate = w_dig_last;
            end
            S_FLUSH: begin
                o_mac.flush = 1'b1;
            end
            S_DONE: begin
                o_load_out = i_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/core/dcfl_checker.sv =====
// port-level checks for dual_channel_fir_lowpass, bound to the top level
// depends on dcfl_pkg and dual_channel_fir_lowpass_macros.svh
`timescale 1ns / 1ps
`include "dual_channel_fir_lowpass_macros.svh"

module dcfl_checker
    import dcfl_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic signed [SAMPLE_BITS-1:0] i_red_sample,
    input logic signed [SAMPLE_BITS-1:0] i_ir_sample,
    input logic signed [SAMPLE_BITS-1:0] i_red_dc_in,
    input logic signed [SAMPLE_BITS-1:0] i_ir_dc_in,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [SAMPLE_BITS-1:0] o_red_filtered,
    input logic signed [SAMPLE_BITS-1:0] o_ir_filtered,
    input logic signed [SAMPLE_BITS-1:0] o_red_dc_out,
    input logic signed [SAMPLE_BITS-1:0] o_ir_dc_out
);

    // stalled input beat keeps valid and payload
    `DCFL_ASSERT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_red_sample) && $stable(i_ir_sample) && $stable(i_red_dc_in) && $stable(i_ir_dc_in), "input beat changed while stalled")

    // stalled output beat keeps valid and payload
    `DCFL_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_red_filtered) && $stable(o_ir_filtered) && $stable(o_red_dc_out) && $stable(o_ir_dc_out), "output beat changed while stalled")

    // one beat at a time in the core
    `DCFL_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input taken while core busy")

    // a new result lands as the core goes idle
    `DCFL_ASSERT(a_idle_on_result, i_clk, i_rst_n, $rose(o_out_valid) |-> !o_in_stall, "core not idle after result")

    `DCFL_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "bad state after reset")

endmodule

bind dual_channel_fir_lowpass dcfl_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_red_sample   (i_red_sample),
    .i_ir_sample    (i_ir_sample),
    .i_red_dc_in    (i_red_dc_in),
    .i_ir_dc_in     (i_ir_dc_in),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_red_filtered (o_red_filtered),
    .o_ir_filtered  (o_ir_filtered),
    .o_red_dc_out   (o_red_dc_out),
    .o_ir_dc_out    (o_ir_dc_out)
);

// ===== tb/sv/dual_channel_fir_lowpass_test.sv =====
// self-checking testbench for dual_channel_fir_lowpass: random and directed sample beats,
// a scoreboard class that runs both 51-tap lanes in software, random stalls on both sides
// depends on dcfl_pkg and the dual_channel_fir_lowpass rtl
`timescale 1ns / 1ps

localparam int N_TAPS       = 51;
localparam int FRAC_BITS    = 15;
localparam int Q20_BITS     = 20;
localparam int MIRROR_TAPS  = 26;
localparam int LANE_COUNT   = 2;
localparam int LANE_RED     = 0;
localparam int LANE_IR      = 1;

typedef logic signed [dcfl_pkg::SAMPLE_BITS-1:0] t_sample;

typedef struct packed {
    t_sample red_filtered;
    t_sample ir_filtered;
    t_sample red_dc;
    t_sample ir_dc;
} t_out_beat;

typedef enum int {
    WAVE_NOISE,
    WAVE_RAIL,
    WAVE_RAMP,
    WAVE_TOGGLE,
    WAVE_QUIET,
    WAVE_SQUARE
} t_wave;

class fir_output_tracker;
    longint      coefs [N_TAPS];
    t_sample     lines [LANE_COUNT][N_TAPS];
    t_out_beat   expected_outputs [$];
    int unsigned mismatches;

    function new();
        int unsigned half_q20 [MIRROR_TAPS];
        int unsigned t;
        int          p;
        int          sh;
        half_q20 = '{
            0, 173, 404, 743, 1242, 1950, 2915, 4176, 5763, 7694,
            9972, 12588, 15513, 18705, 22107, 25648, 29247, 32815,
            36258, 39481, 42392, 44904, 46944, 48447, 49369, 49679
        };
        sh = Q20_BITS - FRAC_BITS;
        for (int i = 0; i < N_TAPS; i++) begin
            p = i;
            if (p >= 2 * MIRROR_TAPS - 1) begin
                coefs[i] = 0;
            end else begin
                if (p >= MIRROR_TAPS) begin
                    p = 2 * MIRROR_TAPS - 2 - p;
                end
                t = half_q20[p];
                if (sh > 0) begin
                    t = (t + (1 << (sh - 1))) >> sh;
                end else if (sh < 0) begin
                    t = t << (-sh);
                end
                coefs[i] = longint'(t);
            end
            for (int k = 0; k < LANE_COUNT; k++) begin
                lines[k][i] = '0;
            end
        end
        mismatches = 0;
    endfunction

    // shift one sample into a lane, then round half up and clip the dot product
    function t_sample run_lane(input int lane, input t_sample s);
        longint acc;
        longint q;
        longint hi;
        longint lo;
        hi = (longint'(1) << (dcfl_pkg::SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        for (int i = N_TAPS - 1; i > 0; i--) begin
            lines[lane][i] = lines[lane][i-1];
        end
        lines[lane][0] = s;
        acc = 0;
        for (int i = 0; i < N_TAPS; i++) begin
            acc += longint'(lines[lane][i]) * coefs[i];
        end
        q = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (q > hi) begin
            q = hi;
        end
        if (q < lo) begin
            q = lo;
        end
        return t_sample'(q);
    endfunction

    function void note_samples(t_sample red, t_sample ir, t_sample red_dc, t_sample ir_dc);
        t_out_beat b;
        b.red_filtered = run_lane(LANE_RED, red);
        b.ir_filtered  = run_lane(LANE_IR, ir);
        b.red_dc       = red_dc;
        b.ir_dc        = ir_dc;
        expected_outputs.push_back(b);
    endfunction

    function void compare_field(string field, t_sample want, t_sample got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    function void check_output(t_out_beat got);
        t_out_beat want;
        if (expected_outputs.size() == 0) begin
            mismatches++;
            $display("%0t: output beat with none pending, actual %0d %0d %0d %0d", $time,
                     got.red_filtered, got.ir_filtered, got.red_dc, got.ir_dc);
        end else begin
            want = expected_outputs.pop_front();
            compare_field("red_filtered", want.red_filtered, got.red_filtered);
            compare_field("ir_filtered", want.ir_filtered, got.ir_filtered);
            compare_field("red_dc_out", want.red_dc, got.red_dc);
            compare_field("ir_dc_out", want.ir_dc, got.ir_dc);
        end
    endfunction
endclass

module dual_channel_fir_lowpass_test;

    localparam int TOTAL_BEATS   = 700;
    localparam int CALM_BEATS    = 80;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 400;

    logic    i_clk        = 1'b0;
    logic    i_rst_n      = 1'b0;
    logic    i_in_valid   = 1'b0;
    logic    o_in_stall;
    t_sample i_red_sample = '0;
    t_sample i_ir_sample  = '0;
    t_sample i_red_dc_in  = '0;
    t_sample i_ir_dc_in   = '0;
    logic    o_out_valid;
    logic    i_out_stall  = 1'b0;
    t_sample o_red_filtered;
    t_sample o_ir_filtered;
    t_sample o_red_dc_out;
    t_sample o_ir_dc_out;

    fir_output_tracker tracker = new();
    int unsigned       beats_sent   = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       idle_odds    = 0;
    int unsigned       stall_odds   = 0;

    dual_channel_fir_lowpass #(
        .TAP_COUNT      (N_TAPS),
        .COEF_FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_red_sample   (i_red_sample),
        .i_ir_sample    (i_ir_sample),
        .i_red_dc_in    (i_red_dc_in),
        .i_ir_dc_in     (i_ir_dc_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red_filtered (o_red_filtered),
        .o_ir_filtered  (o_ir_filtered),
        .o_red_dc_out   (o_red_dc_out),
        .o_ir_dc_out    (o_ir_dc_out)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                tracker.note_samples(i_red_sample, i_ir_sample, i_red_dc_in, i_ir_dc_in);
            end
            if (o_out_valid && !i_out_stall) begin
                tracker.check_output('{o_red_filtered, o_ir_filtered,
                                       o_red_dc_out, o_ir_dc_out});
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_beat(input t_sample red, input t_sample ir,
                             input t_sample red_dc, input t_sample ir_dc);
        i_in_valid   <= 1'b1;
        i_red_sample <= red;
        i_ir_sample  <= ir;
        i_red_dc_in  <= red_dc;
        i_ir_dc_in   <= ir_dc;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
        if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_outputs.size() != 0);
    endtask

    task automatic play_segment(input t_wave wave, input int len);
        t_sample r;
        t_sample ir;
        t_sample amp_r;
        t_sample amp_i;
        t_sample step_r;
        t_sample step_i;
        int      period;
        r      = t_sample'($urandom);
        ir     = t_sample'($urandom);
        amp_r  = t_sample'($urandom);
        amp_i  = t_sample'($urandom);
        step_r = t_sample'($urandom_range(0, 2048) - 1024);
        step_i = t_sample'($urandom_range(0, 2048) - 1024);
        period = $urandom_range(1, 40);
        if (wave == WAVE_RAIL) begin
            r   = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            ir  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            len = len + N_TAPS;
        end
        for (int k = 0; k < len; k++) begin
            case (wave)
                WAVE_NOISE: begin
                    r  = t_sample'($urandom);
                    ir = t_sample'($urandom);
                end
                WAVE_RAMP: begin
                    r  = r + step_r;
                    ir = ir + step_i;
                end
                WAVE_TOGGLE: begin
                    r  = (k % 2) ? amp_r : -amp_r;
                    ir = (k % 2) ? -amp_i : amp_i;
                end
                WAVE_QUIET: begin
                    r  = t_sample'($urandom_range(0, 64) - 32);
                    ir = t_sample'($urandom_range(0, 64) - 32);
                end
                WAVE_SQUARE: begin
                    r  = ((k / period) % 2) ? amp_r : ~amp_r;
                    ir = ((k / period) % 2) ? ~amp_i : amp_i;
                end
                default: begin
                end
            endcase
            send_beat(r, ir, t_sample'($urandom), t_sample'($urandom));
        end
    endtask

    initial begin
        bit mid_drained;
        mid_drained = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, sign and alternating bit patterns, then a run of zero samples and a full-scale run
        idle_odds  = 30;
        stall_odds = 20;
        send_beat(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        send_beat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_beat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_beat(16'shffff, 16'sh0001, 16'shffff, 16'sh0001);
        send_beat(16'sh0001, 16'shffff, 16'sh5555, 16'shaaaa);
        send_beat(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);
        send_beat(16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff);
        repeat (10) send_beat(16'sh0000, 16'sh0000, t_sample'($urandom), t_sample'($urandom));
        repeat (8) send_beat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        drain_outputs();

        while (beats_sent < TOTAL_BEATS - CALM_BEATS) begin
            case ($urandom_range(0, 2))
                0: idle_odds = 0;
                1: idle_odds = 10;
                default: idle_odds = 40;
            endcase
            case ($urandom_range(0, 3))
                0: stall_odds = 0;
                1: stall_odds = 3;
                2: stall_odds = 10;
                default: stall_odds = 30;
            endcase
            play_segment(t_wave'($urandom_range(0, 5)), $urandom_range(8, 60));
            if (!mid_drained && beats_sent > TOTAL_BEATS / 2) begin
                drain_outputs();
                mid_drained = 1'b1;
            end
        end

        idle_odds  = 0;
        stall_odds = 0;
        play_segment(WAVE_NOISE, CALM_BEATS / 4);
        play_segment(WAVE_RAIL, CALM_BEATS / 4);
        play_segment(WAVE_SQUARE, CALM_BEATS / 4);
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.expected_outputs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
